// ----- rtl/core/mfc_pkg.sv -----
// Shared constants, types and mix hash helpers for the memory flip checker.
`default_nettype none
package mfc_pkg;

   localparam int WORD_INDEX_W = 32;
   localparam int WORD_W       = 64;
   localparam int COUNT_W      = 16;
   localparam int BIN_OUT_W    = 8;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int READS_W      = 3;
   localparam int CELLS_W      = 9;

   localparam logic [WORD_W-1:0] MIX_ADD   = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hFF51_AFD7_ED55_8CCD;
   localparam logic [WORD_W-1:0] MIX_MUL_B = 64'hC4CE_B9FE_1A85_EC53;
   localparam logic [WORD_W-1:0] MIX_XOR   = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam int                MIX_SHIFT = 33;

   localparam logic [COUNT_W-1:0] SAT_CLAMP = 16'd9;
   localparam logic [COUNT_W-1:0] SAT_FULL  = 16'hFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VERIFY_COUNT   = 4'd0,
      CSR_CLAMP_TO_NINE  = 4'd1,
      CSR_CELL_COUNT     = 4'd2,
      CSR_WORDS_PER_CELL = 4'd3
   } csr_index_type;

   function automatic logic [WORD_W-1:0] mix_fold(input logic [WORD_W-1:0] v);
      return v ^ (v >> MIX_SHIFT);
   endfunction

   function automatic logic [WORD_W-1:0] mix_finish(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] y;
      y = mix_fold(v);
      return y ^ MIX_XOR ^ (y << 1);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mfc_divider.sv -----
// Radix-2 restoring divider for the region bin of a word index.
`default_nettype none
module mfc_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mfc_pkg::WORD_INDEX_W-1:0]  dividend,
   input  logic [mfc_pkg::WORD_INDEX_W-1:0]  divisor,
   output logic                              done,
   output logic [mfc_pkg::WORD_INDEX_W-1:0]  quotient
);
   import mfc_pkg::*;

   localparam int DIV_W  = WORD_INDEX_W;
   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [DIV_W-1:0]  den_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              done_ff;

   logic [DIV_W:0]    shifted;
   logic [DIV_W:0]    diff;
   logic              fits;
   logic [DIV_W-1:0]  rem_in;
   logic [DIV_W-1:0]  quo_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_in  = {quo_ff[DIV_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         rem_ff  <= '0;
         quo_ff  <= dividend;
         den_ff  <= divisor;
         cnt_ff  <= STEP_W'(DIV_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         cnt_ff  <= cnt_ff - 1'b1;
         done_ff <= (cnt_ff == STEP_W'(1));
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/core/mfc_mix.sv -----
// Mix hash sequencer: two 64-bit multiplies on one shared 32x32 multiplier.
`default_nettype none
module mfc_mix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mfc_pkg::WORD_W-1:0]  idx,
   output logic                        done,
   output logic [mfc_pkg::WORD_W-1:0]  word
);
   import mfc_pkg::*;

   localparam int HALF_W = WORD_W / 2;

   typedef enum logic [1:0] {
      PH_LL,
      PH_LH,
      PH_HL
   } phase_type;

   phase_type         phase_ff;
   logic              busy_ff;
   logic              round_ff;
   logic              done_ff;
   logic [WORD_W-1:0] a_ff;
   logic [WORD_W-1:0] acc_ff;
   logic [WORD_W-1:0] word_ff;

   logic [WORD_W-1:0] k;
   logic [HALF_W-1:0] op_a;
   logic [HALF_W-1:0] op_b;
   logic [WORD_W-1:0] prod;
   logic [WORD_W-1:0] acc_in;

   always_comb begin
      k    = round_ff ? MIX_MUL_B : MIX_MUL_A;
      op_a = a_ff[HALF_W-1:0];
      op_b = k[HALF_W-1:0];
      case (phase_ff)
         PH_LL: begin
            op_a = a_ff[HALF_W-1:0];
            op_b = k[HALF_W-1:0];
         end
         PH_LH: begin
            op_a = a_ff[HALF_W-1:0];
            op_b = k[WORD_W-1:HALF_W];
         end
         PH_HL: begin
            op_a = a_ff[WORD_W-1:HALF_W];
            op_b = k[HALF_W-1:0];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod = WORD_W'(op_a) * WORD_W'(op_b);
      if (phase_ff == PH_LL) begin
         acc_in = prod;
      end else begin
         acc_in = acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_LL;
         round_ff <= 1'b0;
      end else if (start) begin
         a_ff     <= mix_fold(idx + MIX_ADD);
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         phase_ff <= PH_LL;
         round_ff <= 1'b0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         case (phase_ff)
            PH_LL: phase_ff <= PH_LH;
            PH_LH: phase_ff <= PH_HL;
            PH_HL: begin
               phase_ff <= PH_LL;
               if (!round_ff) begin
                  a_ff     <= mix_fold(acc_in);
                  round_ff <= 1'b1;
               end else begin
                  word_ff <= mix_finish(acc_in);
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
            default: phase_ff <= PH_LL;
         endcase
      end
   end

   assign done = done_ff;
   assign word = word_ff;

endmodule
`default_nettype wire

// ----- rtl/core/memory_flip_checker_top.sv -----
// Memory flip checker top level: flip confirmation, region bin counters, flip total.
// Each item passes the 32-step bin divider (the mix hash runs beside it), a bin memory
//   read and a write-back; no new item is taken before its result moves to the output register.
// The next item is accepted while a finished result still waits in the output register.
// Reset: synchronous; bin valid bits clear at once (no clearing pass), total zeroed,
//   configuration registers and control state return to their defaults.
`default_nettype none
module memory_flip_checker_top #(
   parameter int MAX_READS  = 4,
   parameter int BIN_DEPTH  = 256,
   parameter int INDEX_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_clear_bins,
   input  logic [mfc_pkg::WORD_INDEX_W-1:0]  req_word_index,
   input  logic [mfc_pkg::WORD_W-1:0]        req_first_read,
   input  logic [mfc_pkg::WORD_W-1:0]        req_reread_one,
   input  logic [mfc_pkg::WORD_W-1:0]        req_reread_two,
   input  logic [mfc_pkg::WORD_W-1:0]        req_reread_three,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_mismatch_seen,
   output logic                              rsp_flip_confirmed,
   output logic [mfc_pkg::WORD_W-1:0]        rsp_expected_word,
   output logic [mfc_pkg::WORD_W-1:0]        rsp_observed_word,
   output logic [mfc_pkg::WORD_W-1:0]        rsp_flip_mask,
   output logic [mfc_pkg::BIN_OUT_W-1:0]     rsp_bin_index,
   output logic [mfc_pkg::COUNT_W-1:0]       rsp_bin_count,
   output logic [mfc_pkg::WORD_W-1:0]        rsp_detected_total,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mfc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mfc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mfc_pkg::*;

   localparam int IDX_W   = (INDEX_BITS < WORD_INDEX_W) ? INDEX_BITS : WORD_INDEX_W;
   localparam int BIN_W   = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
   localparam int N_READS = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_READ,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic [READS_W-1:0]      verify_count_ff;
   logic                    clamp_ff;
   logic [CELLS_W-1:0]      cell_count_ff;
   logic [WORD_INDEX_W-1:0] words_per_cell_ff;

   logic [WORD_W-1:0]       reads_ff [N_READS];
   logic [WORD_W-1:0]       total_ff;

   logic [COUNT_W-1:0]      bins_mem [BIN_DEPTH];
   logic [BIN_DEPTH-1:0]    valid_ff;
   logic [COUNT_W-1:0]      rd_data_ff;

   logic [BIN_W-1:0]        bin_addr_ff;
   logic [WORD_W-1:0]       exp_ff;
   logic [WORD_W-1:0]       obs_ff;
   logic                    mism_ff;
   logic                    conf_ff;
   logic [COUNT_W-1:0]      cnt_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_mismatch_ff;
   logic                    rsp_confirmed_ff;
   logic [WORD_W-1:0]       rsp_expected_ff;
   logic [WORD_W-1:0]       rsp_observed_ff;
   logic [WORD_W-1:0]       rsp_mask_ff;
   logic [BIN_OUT_W-1:0]    rsp_bin_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic [WORD_W-1:0]       rsp_total_ff;

   logic                    accept;
   logic                    calc_done;
   logic                    out_free;
   logic [WORD_INDEX_W-1:0] idx_masked;
   logic                    div_done;
   logic [WORD_INDEX_W-1:0] quotient;
   logic                    mix_done;
   logic [WORD_W-1:0]       mix_word;
   logic [WORD_INDEX_W-1:0] divisor;
   logic [READS_W-1:0]      vc_eff;
   logic [WORD_INDEX_W-1:0] cells_eff;
   logic [WORD_INDEX_W-1:0] bin_lim;
   logic [WORD_INDEX_W-1:0] bin_full;
   logic [BIN_W-1:0]        bin_addr_in;
   logic                    mism_in;
   logic                    conf_in;
   logic [WORD_W-1:0]       obs_in;
   logic [COUNT_W-1:0]      old_count;
   logic [COUNT_W-1:0]      sat_limit;
   logic [COUNT_W-1:0]      cnt_in;
   logic                    mem_we;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign csr_ready = !reset;
   assign calc_done = (state_ff == ST_CALC) && div_done && mix_done;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mem_we    = (state_ff == ST_READ);

   assign idx_masked = WORD_INDEX_W'(req_word_index[IDX_W-1:0]);
   assign divisor    = (words_per_cell_ff == '0) ? WORD_INDEX_W'(1) : words_per_cell_ff;

   mfc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (idx_masked),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   mfc_mix u_mix (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .idx   (WORD_W'(idx_masked)),
      .done  (mix_done),
      .word  (mix_word)
   );

   always_comb begin
      if (verify_count_ff == '0) begin
         vc_eff = READS_W'(1);
      end else if (verify_count_ff > READS_W'(MAX_READS)) begin
         vc_eff = READS_W'(MAX_READS);
      end else begin
         vc_eff = verify_count_ff;
      end
      cells_eff = WORD_INDEX_W'(cell_count_ff);
      if (cells_eff == '0) begin
         cells_eff = WORD_INDEX_W'(1);
      end else if (cells_eff > WORD_INDEX_W'(BIN_DEPTH)) begin
         cells_eff = WORD_INDEX_W'(BIN_DEPTH);
      end
      bin_lim     = cells_eff - 1'b1;
      bin_full    = (quotient > bin_lim) ? bin_lim : quotient;
      bin_addr_in = bin_full[BIN_W-1:0];
   end

   always_comb begin
      mism_in = (reads_ff[0] != mix_word);
      conf_in = mism_in;
      obs_in  = reads_ff[0];
      if (mism_in) begin
         for (int i = 1; i < N_READS; i++) begin
            if (READS_W'(i) < vc_eff) begin
               obs_in = reads_ff[i];
               if (reads_ff[i] == mix_word) begin
                  conf_in = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      old_count = valid_ff[bin_addr_ff] ? rd_data_ff : '0;
      sat_limit = clamp_ff ? SAT_CLAMP : SAT_FULL;
      cnt_in    = old_count;
      if (conf_ff && (old_count < sat_limit)) begin
         cnt_in = old_count + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         verify_count_ff   <= READS_W'(2);
         clamp_ff          <= 1'b1;
         cell_count_ff     <= CELLS_W'(240);
         words_per_cell_ff <= WORD_INDEX_W'(559240);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VERIFY_COUNT:   verify_count_ff   <= csr_wdata[READS_W-1:0];
            CSR_CLAMP_TO_NINE:  clamp_ff          <= csr_wdata[0];
            CSR_CELL_COUNT:     cell_count_ff     <= csr_wdata[CELLS_W-1:0];
            CSR_WORDS_PER_CELL: words_per_cell_ff <= csr_wdata[WORD_INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         reads_ff[0] <= req_first_read;
         reads_ff[1] <= req_reread_one;
         reads_ff[2] <= req_reread_two;
         reads_ff[3] <= req_reread_three;
      end
      if (calc_done) begin
         bin_addr_ff <= bin_addr_in;
         exp_ff      <= mix_word;
         obs_ff      <= obs_in;
         mism_ff     <= mism_in;
         conf_ff     <= conf_in;
      end
      if (mem_we) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (mem_we && conf_ff) begin
         total_ff <= total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (accept && req_clear_bins) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[bin_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bins_mem[bin_addr_ff] <= cnt_in;
      end
      if (calc_done) begin
         rd_data_ff <= bins_mem[bin_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               if (calc_done) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_mismatch_ff  <= mism_ff;
                  rsp_confirmed_ff <= conf_ff;
                  rsp_expected_ff  <= exp_ff;
                  rsp_observed_ff  <= obs_ff;
                  rsp_mask_ff      <= exp_ff ^ obs_ff;
                  rsp_bin_ff       <= BIN_OUT_W'(bin_addr_ff);
                  rsp_count_ff     <= cnt_ff;
                  rsp_total_ff     <= total_ff;
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mismatch_seen  = rsp_mismatch_ff;
   assign rsp_flip_confirmed = rsp_confirmed_ff;
   assign rsp_expected_word  = rsp_expected_ff;
   assign rsp_observed_word  = rsp_observed_ff;
   assign rsp_flip_mask      = rsp_mask_ff;
   assign rsp_bin_index      = rsp_bin_ff;
   assign rsp_bin_count      = rsp_count_ff;
   assign rsp_detected_total = rsp_total_ff;

   a_mask_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_flip_mask == (rsp_expected_word ^ rsp_observed_word)))
      else $error("flip mask does not match expected and observed words");

   a_confirm_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flip_confirmed) |-> (rsp_mismatch_seen && (rsp_bin_count != '0)))
      else $error("confirmed flip without mismatch or bin count");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((total_ff == $past(total_ff)) ||
                         (total_ff == $past(total_ff) + 64'd1)))
      else $error("flip total moved by more than one");

   a_read_after_calc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ($past(state_ff) == ST_CALC && $past(div_done) &&
                                 $past(mix_done)))
      else $error("bin read without finished hash and divide");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CALC && !div_done && !mix_done))
      else $error("accepted item did not start the units");

endmodule
`default_nettype wire

// ----- tb/memory_flip_checker_top_tb.sv -----
// Self-checking testbench for the memory flip checker: directed and random scans.
`timescale 1ns / 100ps
module memory_flip_checker_top_tb;
   import mfc_pkg::*;

   localparam int MAX_READS  = 4;
   localparam int BIN_DEPTH  = 256;
   localparam int INDEX_BITS = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = 4'd4;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic                      clear_bins;
      logic [WORD_INDEX_W-1:0]   word_index;
      logic [WORD_W-1:0]         first_read;
      logic [WORD_W-1:0]         reread_one;
      logic [WORD_W-1:0]         reread_two;
      logic [WORD_W-1:0]         reread_three;
   } scan_item_type;

   typedef struct packed {
      logic                      mismatch_seen;
      logic                      flip_confirmed;
      logic [WORD_W-1:0]         expected_word;
      logic [WORD_W-1:0]         observed_word;
      logic [WORD_W-1:0]         flip_mask;
      logic [BIN_OUT_W-1:0]      bin_index;
      logic [COUNT_W-1:0]        bin_count;
      logic [WORD_W-1:0]         detected_total;
   } scan_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_clear_bins = 1'b0;
   logic [WORD_INDEX_W-1:0]   req_word_index = '0;
   logic [WORD_W-1:0]         req_first_read = '0;
   logic [WORD_W-1:0]         req_reread_one = '0;
   logic [WORD_W-1:0]         req_reread_two = '0;
   logic [WORD_W-1:0]         req_reread_three = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_mismatch_seen;
   logic                      rsp_flip_confirmed;
   logic [WORD_W-1:0]         rsp_expected_word;
   logic [WORD_W-1:0]         rsp_observed_word;
   logic [WORD_W-1:0]         rsp_flip_mask;
   logic [BIN_OUT_W-1:0]      rsp_bin_index;
   logic [COUNT_W-1:0]        rsp_bin_count;
   logic [WORD_W-1:0]         rsp_detected_total;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   scan_item_type   pending_scans [$];
   scan_result_type expected_results [$];

   logic [READS_W-1:0]        model_reads;
   logic                      model_clamp;
   logic [CELLS_W-1:0]        model_cells;
   logic [CSR_DATA_W-1:0]     model_wpc;
   logic [COUNT_W-1:0]        region_counts [BIN_DEPTH];
   logic [WORD_W-1:0]         flip_count;

   int send_idle_pct = 6;
   int recv_idle_pct = 79;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int mismatch_count = 0;
   logic [WORD_INDEX_W-1:0] last_word_index = '0;

   memory_flip_checker_top #(
      .MAX_READS  (MAX_READS),
      .BIN_DEPTH  (BIN_DEPTH),
      .INDEX_BITS (INDEX_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_clear_bins     (req_clear_bins),
      .req_word_index     (req_word_index),
      .req_first_read     (req_first_read),
      .req_reread_one     (req_reread_one),
      .req_reread_two     (req_reread_two),
      .req_reread_three   (req_reread_three),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mismatch_seen  (rsp_mismatch_seen),
      .rsp_flip_confirmed (rsp_flip_confirmed),
      .rsp_expected_word  (rsp_expected_word),
      .rsp_observed_word  (rsp_observed_word),
      .rsp_flip_mask      (rsp_flip_mask),
      .rsp_bin_index      (rsp_bin_index),
      .rsp_bin_count      (rsp_bin_count),
      .rsp_detected_total (rsp_detected_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] pattern_for_index(
      input logic [WORD_INDEX_W-1:0] idx);
      logic [WORD_W-1:0] x;
      x = {{(WORD_W-WORD_INDEX_W){1'b0}}, idx} + MIX_ADD;
      x = x ^ (x >> MIX_SHIFT);
      x = x * MIX_MUL_A;
      x = x ^ (x >> MIX_SHIFT);
      x = x * MIX_MUL_B;
      x = x ^ (x >> MIX_SHIFT);
      return x ^ MIX_XOR ^ (x << 1);
   endfunction

   function automatic int effective_reads(input logic [READS_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_READS) return MAX_READS;
      return int'(v);
   endfunction

   function automatic int effective_cells(input logic [CELLS_W-1:0] v);
      if (v == 0) return 1;
      if (v > BIN_DEPTH) return BIN_DEPTH;
      return int'(v);
   endfunction

   function automatic logic [WORD_W-1:0] effective_wpc(input logic [CSR_DATA_W-1:0] v);
      if (v == 0) return 64'd1;
      return {32'd0, v};
   endfunction

   function automatic scan_result_type predict_scan(input scan_item_type it);
      scan_result_type res;
      logic [WORD_W-1:0] reads [4];
      logic [WORD_W-1:0] bin;
      logic [COUNT_W-1:0] cnt;
      int nreads;
      int cells;
      nreads = effective_reads(model_reads);
      cells  = effective_cells(model_cells);
      reads[0] = it.first_read;
      reads[1] = it.reread_one;
      reads[2] = it.reread_two;
      reads[3] = it.reread_three;
      if (it.clear_bins)
         for (int b = 0; b < BIN_DEPTH; b++) region_counts[b] = '0;
      res.expected_word  = pattern_for_index(it.word_index);
      res.observed_word  = reads[0];
      res.mismatch_seen  = (reads[0] != res.expected_word);
      res.flip_confirmed = res.mismatch_seen;
      if (res.mismatch_seen) begin
         for (int r = 1; r < nreads; r++) begin
            res.observed_word = reads[r];
            if (reads[r] == res.expected_word) res.flip_confirmed = 1'b0;
         end
      end
      bin = {32'd0, it.word_index} / effective_wpc(model_wpc);
      if (bin > cells - 1) bin = cells - 1;
      if (res.flip_confirmed) begin
         cnt = region_counts[bin];
         if (model_clamp) begin
            if (cnt < SAT_CLAMP) cnt = cnt + 1'b1;
         end else begin
            if (cnt < SAT_FULL) cnt = cnt + 1'b1;
         end
         region_counts[bin] = cnt;
         flip_count = flip_count + 1'b1;
      end
      res.flip_mask      = res.expected_word ^ res.observed_word;
      res.bin_index      = bin[BIN_OUT_W-1:0];
      res.bin_count      = region_counts[bin];
      res.detected_total = flip_count;
      return res;
   endfunction

   always @(posedge clock) begin : predict
      scan_item_type seen;
      if (reset) begin
         model_reads = 3'd2;
         model_clamp = 1'b1;
         model_cells = 9'd240;
         model_wpc   = 32'd559240;
         flip_count  = '0;
         for (int b = 0; b < BIN_DEPTH; b++) region_counts[b] = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VERIFY_COUNT:   model_reads = csr_wdata[READS_W-1:0];
               CSR_CLAMP_TO_NINE:  model_clamp = csr_wdata[0];
               CSR_CELL_COUNT:     model_cells = csr_wdata[CELLS_W-1:0];
               CSR_WORDS_PER_CELL: model_wpc   = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            seen.clear_bins   = req_clear_bins;
            seen.word_index   = req_word_index;
            seen.first_read   = req_first_read;
            seen.reread_one   = req_reread_one;
            seen.reread_two   = req_reread_two;
            seen.reread_three = req_reread_three;
            expected_results.push_back(predict_scan(seen));
         end
      end
   end

   always @(posedge clock) begin : drive
      scan_item_type next_scan;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_scans.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_scan = pending_scans.pop_front();
            req_clear_bins   <= next_scan.clear_bins;
            req_word_index   <= next_scan.word_index;
            req_first_read   <= next_scan.first_read;
            req_reread_one   <= next_scan.reread_one;
            req_reread_two   <= next_scan.reread_two;
            req_reread_three <= next_scan.reread_three;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      scan_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result item with no expected item waiting");
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("mismatch_seen", 64'(want.mismatch_seen), 64'(rsp_mismatch_seen));
            compare_field("flip_confirmed", 64'(want.flip_confirmed), 64'(rsp_flip_confirmed));
            compare_field("expected_word", want.expected_word, rsp_expected_word);
            compare_field("observed_word", want.observed_word, rsp_observed_word);
            compare_field("flip_mask", want.flip_mask, rsp_flip_mask);
            compare_field("bin_index", 64'(want.bin_index), 64'(rsp_bin_index));
            compare_field("bin_count", 64'(want.bin_count), 64'(rsp_bin_count));
            compare_field("detected_total", want.detected_total, rsp_detected_total);
         end
      end
   end

   task automatic queue_scan(input logic clear, input logic [WORD_INDEX_W-1:0] idx,
                             input logic [WORD_W-1:0] r0, input logic [WORD_W-1:0] r1,
                             input logic [WORD_W-1:0] r2, input logic [WORD_W-1:0] r3);
      scan_item_type it;
      it.clear_bins   = clear;
      it.word_index   = idx;
      it.first_read   = r0;
      it.reread_one   = r1;
      it.reread_two   = r2;
      it.reread_three = r3;
      pending_scans.push_back(it);
   endtask

   task automatic wait_drained();
      while (pending_scans.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // call at a rising edge; returns at the accepting edge with valid still high
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input int reads, input int clamp, input int cells,
                             input logic [CSR_DATA_W-1:0] wpc);
      wait_drained();
      @(posedge clock);
      csr_write(CSR_VERIFY_COUNT, ($urandom & ~32'h7) | (reads & 32'h7));
      csr_write(CSR_CLAMP_TO_NINE, ($urandom & ~32'h1) | (clamp & 32'h1));
      csr_write(CSR_CELL_COUNT, ($urandom & ~32'h1FF) | (cells & 32'h1FF));
      csr_write(CSR_FIRST_UNUSED + CSR_INDEX_W'($urandom_range(0, 11)), $urandom);
      csr_write(CSR_WORDS_PER_CELL, wpc);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_random_scan();
      logic [WORD_INDEX_W-1:0] idx;
      logic [WORD_W-1:0] e, m;
      logic [WORD_W-1:0] rd [4];
      int nreads, cells, pick;
      nreads = effective_reads(model_reads);
      cells  = effective_cells(model_cells);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: idx = $urandom;
         4, 5, 6:    idx = $urandom_range(0, 4095);
         7:          idx = 32'hFFFF_FFFF - $urandom_range(0, 4095);
         8:          idx = 32'($urandom_range(0, cells - 1) * effective_wpc(model_wpc))
                           + $urandom_range(0, 3);
         default:    idx = last_word_index;
      endcase
      last_word_index = idx;
      e = pattern_for_index(idx);
      m = 64'd1;
      for (int i = 0; i < 4; i++) rd[i] = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         rd[0] = e;
         for (int i = 1; i < 4; i++) if ($urandom_range(0, 1)) rd[i] = e;
      end else if (pick < 85) begin
         for (int i = 0; i < 4; i++) begin
            if (i == 0 || $urandom_range(0, 1)) begin
               case ($urandom_range(0, 2))
                  0:       m = 64'd1 << $urandom_range(0, 63);
                  1:       m = {$urandom, $urandom};
                  default: m = (64'd1 << $urandom_range(0, 63)) |
                               (64'd1 << $urandom_range(0, 63));
               endcase
               if (m == 0) m = 64'd1;
            end
            rd[i] = e ^ m;
         end
         if (pick >= 70 && nreads > 1) rd[$urandom_range(1, nreads - 1)] = e;
         for (int i = nreads; i < 4; i++) if ($urandom_range(0, 1)) rd[i] = e;
      end
      queue_scan($urandom_range(0, 49) == 0, idx, rd[0], rd[1], rd[2], rd[3]);
   endtask

   initial begin
      logic [WORD_W-1:0] e;
      logic [WORD_INDEX_W-1:0] idx;
      int cells;
      logic [CSR_DATA_W-1:0] wpc;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults, with hits, misses, a rejected flip and a clear
      set_config(2, 1, 240, 32'd559240);
      e = pattern_for_index(32'd0);
      queue_scan(1'b0, 32'd0, e, e, e, e);
      queue_scan(1'b0, 32'd0, e ^ 64'd1, e, ~e, ~e);
      queue_scan(1'b1, 32'd0, e ^ 64'h8000_0000_0000_0000, ~e, ~e, ~e);
      e = pattern_for_index(32'hFFFF_FFFF);
      queue_scan(1'b0, 32'hFFFF_FFFF, ~e, ~e, ~e, ~e);

      // single read confirms on its own; one bin
      set_config(1, 1, 1, 32'd1);
      e = pattern_for_index(32'd7);
      queue_scan(1'b0, 32'd7, e ^ 64'd2, e, e, e);

      // four reads; the last one decides
      set_config(4, 1, 256, 32'd1);
      e = pattern_for_index(32'hFFFF_FFFF);
      queue_scan(1'b0, 32'hFFFF_FFFF, ~e, ~e, ~e, e);
      queue_scan(1'b0, 32'hFFFF_FFFF, ~e, e ^ 64'd4, ~e, e ^ 64'd1);

      // zero cells and zero words per cell; unused fourth read ignored
      set_config(3, 0, 0, 32'd0);
      idx = $urandom;
      e = pattern_for_index(idx);
      queue_scan(1'b0, idx, ~e, ~e, ~e, e);

      // zero reads, oversized cell count, widest cells
      set_config(0, 1, 511, 32'hFFFF_FFFF);
      e = pattern_for_index(32'hFFFF_FFFF);
      queue_scan(1'b0, 32'hFFFF_FFFF, e ^ 64'd1, e, e, e);

      // count past nine with clamp off, then hold it with clamp on
      set_config(7, 0, 2, 32'd1);
      e = pattern_for_index(32'd1);
      repeat (10) queue_scan(1'b0, 32'd1, ~e, ~e, ~e, ~e);
      set_config(2, 1, 2, 32'd1);
      queue_scan(1'b0, 32'd1, ~e, ~e, e, e);
      queue_scan(1'b1, 32'd1, ~e, ~e, e, e);

      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 7))
            0:       cells = 0;
            1:       cells = 1;
            2:       cells = $urandom_range(2, 16);
            3:       cells = 240;
            4:       cells = 256;
            5:       cells = $urandom_range(257, 511);
            6:       cells = $urandom_range(1, 256);
            default: cells = 16;
         endcase
         case ($urandom_range(0, 6))
            0:       wpc = 32'd0;
            1:       wpc = 32'd1;
            2:       wpc = $urandom_range(1, 64);
            3:       wpc = $urandom_range(1, 4096);
            4:       wpc = 32'd559240;
            5:       wpc = 32'hFFFF_FFFF;
            default: wpc = $urandom;
         endcase
         set_config($urandom_range(0, 7), $urandom_range(0, 1), cells, wpc);
         if (phase == 4) begin
            send_idle_pct = 79;
            recv_idle_pct = 6;
         end else if (phase == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (132) queue_random_scan();
         if (phase == 1 || phase == 9) hold_requests++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/mfc_pkg.sv
rtl/core/mfc_divider.sv
rtl/core/mfc_mix.sv
rtl/core/memory_flip_checker_top.sv
tb/memory_flip_checker_top_tb.sv
